@@ hdl/tcm_pkg.sv @@
`timescale 1ns / 1ps

package tcm_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int COORD_BITS = 12;
   localparam int CSR_DATA_BITS = (SAMPLE_BITS > COORD_BITS) ? SAMPLE_BITS : COORD_BITS;
   localparam int CSR_INDEX_BITS = 3;
   localparam int ORIENT_BITS = 3;
   localparam int PROD_BITS = SAMPLE_BITS + COORD_BITS;

   // Axis pipeline: difference, multiply, range check, one stage per quotient
   // bit, then the clamp stage.
   localparam int AXIS_LATENCY = COORD_BITS + 4;

   localparam int ORIENT_SWAP = 0;
   localparam int ORIENT_INV_X = 1;
   localparam int ORIENT_INV_Y = 2;

   localparam logic [SAMPLE_BITS-1:0] RAW_MIN_RESET = SAMPLE_BITS'(200);
   localparam logic [SAMPLE_BITS-1:0] RAW_MAX_RESET = SAMPLE_BITS'(3900);
   localparam logic [COORD_BITS-1:0] WIDTH_RESET = COORD_BITS'(320);
   localparam logic [COORD_BITS-1:0] HEIGHT_RESET = COORD_BITS'(240);
   localparam logic [ORIENT_BITS-1:0] ORIENT_RESET = '0;
   localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = SAMPLE_BITS'(100);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RAW_X_MIN,
      CSR_RAW_X_MAX,
      CSR_RAW_Y_MIN,
      CSR_RAW_Y_MAX,
      CSR_SCREEN_WIDTH,
      CSR_SCREEN_HEIGHT,
      CSR_ORIENTATION,
      CSR_PRESS_THRESHOLD
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] raw;
      logic [SAMPLE_BITS-1:0] lo;
      logic [SAMPLE_BITS-1:0] hi;
      logic [COORD_BITS-1:0] size;
      logic invert;
   } axis_in_type;

endpackage

@@ hdl/tcm_chan_if.sv @@
`timescale 1ns / 1ps

interface tcm_req_if;
   logic valid;
   logic ready;
   logic [tcm_pkg::SAMPLE_BITS-1:0] pressure;
   logic [tcm_pkg::SAMPLE_BITS-1:0] x_first;
   logic [tcm_pkg::SAMPLE_BITS-1:0] y_first;
   logic [tcm_pkg::SAMPLE_BITS-1:0] x_second;
   logic [tcm_pkg::SAMPLE_BITS-1:0] y_second;

   modport source (output valid, pressure, x_first, y_first, x_second, y_second,
                   input ready);
   modport sink (input valid, pressure, x_first, y_first, x_second, y_second,
                 output ready);
endinterface

interface tcm_rsp_if;
   logic valid;
   logic ready;
   logic pressed;
   logic [tcm_pkg::COORD_BITS-1:0] screen_x;
   logic [tcm_pkg::COORD_BITS-1:0] screen_y;

   modport source (output valid, pressed, screen_x, screen_y, input ready);
   modport sink (input valid, pressed, screen_x, screen_y, output ready);
endinterface

@@ hdl/touch_coordinate_mapper_top.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Ports      Carries
// req_chan  in   tcm_req_if pressure, x_first, y_first, x_second, y_second
// rsp_chan  out  tcm_rsp_if pressed, screen_x, screen_y
// csr_*     in   write port csr_we, csr_index, csr_data
//
// One word is accepted every cycle while req_chan.ready is high; each gives one result word.
// The axis divider develops one quotient bit per stage.
// The whole pipeline advances together; when the output word is not taken, every
// stage holds and req_chan.ready drops.
// Reset is synchronous; it clears the valid bits and loads the register defaults.

module touch_coordinate_mapper_top (
   input  logic clock,
   input  logic reset,
   tcm_req_if.sink req_chan,
   tcm_rsp_if.source rsp_chan,
   input  logic csr_we,
   input  logic [tcm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tcm_pkg::CSR_DATA_BITS-1:0] csr_data
);

   localparam int S = tcm_pkg::SAMPLE_BITS;
   localparam int C = tcm_pkg::COORD_BITS;
   localparam int L = tcm_pkg::AXIS_LATENCY;

   // Configuration registers
   logic [S-1:0] raw_x_min_ff, raw_x_max_ff, raw_y_min_ff, raw_y_max_ff;
   logic [S-1:0] threshold_ff;
   logic [C-1:0] width_ff, height_ff;
   logic [tcm_pkg::ORIENT_BITS-1:0] orient_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_x_min_ff <= tcm_pkg::RAW_MIN_RESET;
         raw_x_max_ff <= tcm_pkg::RAW_MAX_RESET;
         raw_y_min_ff <= tcm_pkg::RAW_MIN_RESET;
         raw_y_max_ff <= tcm_pkg::RAW_MAX_RESET;
         width_ff <= tcm_pkg::WIDTH_RESET;
         height_ff <= tcm_pkg::HEIGHT_RESET;
         orient_ff <= tcm_pkg::ORIENT_RESET;
         threshold_ff <= tcm_pkg::THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (tcm_pkg::csr_index_type'(csr_index))
            tcm_pkg::CSR_RAW_X_MIN: raw_x_min_ff <= csr_data[S-1:0];
            tcm_pkg::CSR_RAW_X_MAX: raw_x_max_ff <= csr_data[S-1:0];
            tcm_pkg::CSR_RAW_Y_MIN: raw_y_min_ff <= csr_data[S-1:0];
            tcm_pkg::CSR_RAW_Y_MAX: raw_y_max_ff <= csr_data[S-1:0];
            tcm_pkg::CSR_SCREEN_WIDTH: width_ff <= csr_data[C-1:0];
            tcm_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_data[C-1:0];
            tcm_pkg::CSR_ORIENTATION: orient_ff <= csr_data[tcm_pkg::ORIENT_BITS-1:0];
            tcm_pkg::CSR_PRESS_THRESHOLD: threshold_ff <= csr_data[S-1:0];
         endcase
      end
   end

   // Global advance: the pipeline moves whenever the output register is free.
   logic en;
   logic rsp_valid_ff;

   assign en = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // Input stage: threshold test and averaging.
   logic s0_valid_ff, s0_pressed_ff;
   logic [S-1:0] s0_ax_ff, s0_ay_ff;
   logic [S:0] sum_x, sum_y;

   assign sum_x = {1'b0, req_chan.x_first} + {1'b0, req_chan.x_second};
   assign sum_y = {1'b0, req_chan.y_first} + {1'b0, req_chan.y_second};

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_pressed_ff <= req_chan.pressure > threshold_ff;
         s0_ax_ff <= sum_x[S:1];
         s0_ay_ff <= sum_y[S:1];
      end
   end

   // Axis routing. In swap mode each raw axis keeps its own calibration span.
   tcm_pkg::axis_in_type x_in, y_in;
   logic swap;

   assign swap = orient_ff[tcm_pkg::ORIENT_SWAP];

   always_comb begin
      x_in.raw = swap ? s0_ay_ff : s0_ax_ff;
      x_in.lo = swap ? raw_y_min_ff : raw_x_min_ff;
      x_in.hi = swap ? raw_y_max_ff : raw_x_max_ff;
      x_in.size = width_ff;
      x_in.invert = orient_ff[tcm_pkg::ORIENT_INV_X];
      y_in.raw = swap ? s0_ax_ff : s0_ay_ff;
      y_in.lo = swap ? raw_x_min_ff : raw_y_min_ff;
      y_in.hi = swap ? raw_x_max_ff : raw_y_max_ff;
      y_in.size = height_ff;
      y_in.invert = orient_ff[tcm_pkg::ORIENT_INV_Y];
   end

   logic [C-1:0] x_coord, y_coord;

   tcm_axis u_axis_x (
      .clock   (clock),
      .en      (en),
      .axis_in (x_in),
      .coord   (x_coord)
   );

   tcm_axis u_axis_y (
      .clock   (clock),
      .en      (en),
      .axis_in (y_in),
      .coord   (y_coord)
   );

   // Valid and pressed bits travel alongside the axis stages.
   logic [L-1:0] vp_ff;
   logic [L-1:0] pp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= '0;
      end else if (en) begin
         vp_ff <= {vp_ff[L-2:0], s0_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff <= {pp_ff[L-2:0], s0_pressed_ff};
      end
   end

   // Output register
   logic pressed_ff;
   logic [C-1:0] screen_x_ff, screen_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vp_ff[L-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pressed_ff <= pp_ff[L-1];
         screen_x_ff <= pp_ff[L-1] ? x_coord : '0;
         screen_y_ff <= pp_ff[L-1] ? y_coord : '0;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.pressed = pressed_ff;
   assign rsp_chan.screen_x = screen_x_ff;
   assign rsp_chan.screen_y = screen_y_ff;

   a_x_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && pressed_ff && (width_ff != '0) |-> screen_x_ff < width_ff)
      else $error("screen_x outside the screen width");

   a_y_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && pressed_ff && (height_ff != '0) |-> screen_y_ff < height_ff)
      else $error("screen_y outside the screen height");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vp_ff) && $stable(s0_valid_ff))
      else $error("pipeline moved during a stall");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> s0_valid_ff)
      else $error("accepted word did not enter the pipeline");

endmodule

@@ hdl/tcm_axis.sv @@
`timescale 1ns / 1ps

module tcm_axis (
   input  logic clock,
   input  logic en,
   input  tcm_pkg::axis_in_type axis_in,
   output logic [tcm_pkg::COORD_BITS-1:0] coord
);

   localparam int S = tcm_pkg::SAMPLE_BITS;
   localparam int C = tcm_pkg::COORD_BITS;
   localparam int P = tcm_pkg::PROD_BITS;

   typedef struct packed {
      logic neg;
      logic span_ok;
      logic big;
      logic inv;
      logic [S-1:0] rem;
      logic [C-1:0] low;
      logic [C-1:0] quo;
      logic [S-1:0] span;
      logic [C-1:0] size;
   } div_type;

   // Difference stage
   logic [S:0] diff;
   logic [S:0] span_full;
   logic a_neg_ff, a_span_ok_ff, a_inv_ff;
   logic [S-1:0] a_mag_ff, a_span_ff;
   logic [C-1:0] a_size_ff;

   assign diff = {1'b0, axis_in.raw} - {1'b0, axis_in.lo};
   assign span_full = {1'b0, axis_in.hi} - {1'b0, axis_in.lo};

   always_ff @(posedge clock) begin
      if (en) begin
         a_neg_ff <= diff[S];
         a_mag_ff <= diff[S] ? S'(axis_in.lo - axis_in.raw) : diff[S-1:0];
         a_span_ok_ff <= !span_full[S] && (span_full[S-1:0] != '0);
         a_span_ff <= span_full[S-1:0];
         a_size_ff <= axis_in.size;
         a_inv_ff <= axis_in.invert;
      end
   end

   // Multiply stage
   logic b_neg_ff, b_span_ok_ff, b_inv_ff;
   logic [P-1:0] b_prod_ff;
   logic [S-1:0] b_span_ff;
   logic [C-1:0] b_size_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         b_prod_ff <= P'(a_mag_ff) * P'(a_size_ff);
         b_neg_ff <= a_neg_ff;
         b_span_ok_ff <= a_span_ok_ff;
         b_span_ff <= a_span_ff;
         b_size_ff <= a_size_ff;
         b_inv_ff <= a_inv_ff;
      end
   end

   // Range check: a quotient that needs more than C bits is past any screen
   // size, so only C quotient bits are ever developed.
   logic big;
   div_type div_init;
   div_type div_ff [0:C];
   div_type div_in [1:C];

   assign big = b_prod_ff[P-1:C] >= b_span_ff;

   always_comb begin
      div_init.neg = b_neg_ff;
      div_init.span_ok = b_span_ok_ff;
      div_init.big = big;
      div_init.inv = b_inv_ff;
      div_init.rem = big ? '0 : b_prod_ff[P-1:C];
      div_init.low = b_prod_ff[C-1:0];
      div_init.quo = '0;
      div_init.span = b_span_ff;
      div_init.size = b_size_ff;
   end

   // One restoring division step per stage.
   always_comb begin
      logic [S:0] trial;
      logic ge;
      for (int g = 0; g < C; g++) begin
         trial = {div_ff[g].rem, div_ff[g].low[C-1]};
         ge = trial >= {1'b0, div_ff[g].span};
         div_in[g+1] = div_ff[g];
         div_in[g+1].rem = ge ? S'(trial - {1'b0, div_ff[g].span}) : trial[S-1:0];
         div_in[g+1].low = {div_ff[g].low[C-2:0], 1'b0};
         div_in[g+1].quo = {div_ff[g].quo[C-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff[0] <= div_init;
         for (int g = 1; g <= C; g++) begin
            div_ff[g] <= div_in[g];
         end
      end
   end

   // Invert and clamp stage
   div_type fin;
   logic zero_v, is_neg, is_big;
   logic [C-1:0] top_val;
   logic [C-1:0] coord_in;
   logic [C-1:0] coord_ff;

   assign fin = div_ff[C];

   always_comb begin
      zero_v = !fin.span_ok || (!fin.big && (fin.quo == '0));
      is_neg = fin.neg && !zero_v;
      is_big = !zero_v && !is_neg && (fin.big || (fin.quo >= fin.size));
      top_val = fin.size - C'(1);
      if (fin.size == '0) begin
         coord_in = '0;
      end else if (!fin.inv) begin
         if (zero_v || is_neg) begin
            coord_in = '0;
         end else if (is_big) begin
            coord_in = top_val;
         end else begin
            coord_in = fin.quo;
         end
      end else begin
         if (zero_v || is_neg) begin
            coord_in = top_val;
         end else if (is_big) begin
            coord_in = '0;
         end else begin
            coord_in = top_val - fin.quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         coord_ff <= coord_in;
      end
   end

   assign coord = coord_ff;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import tcm_pkg::*;

   localparam int PIPE_LATENCY = COORD_BITS + 6;
   localparam int MAX_SAMPLE = (1 << SAMPLE_BITS) - 1;
   localparam int MAX_COORD = (1 << COORD_BITS) - 1;
   localparam int MAX_CSR_DATA = (1 << CSR_DATA_BITS) - 1;
   localparam int RANDOM_PHASES = 12;
   localparam int WORDS_PER_PHASE = 125;
   localparam int HOLD_PHASE = 4;
   localparam int PAUSE_PHASE = 7;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] pressure;
      logic [SAMPLE_BITS-1:0] x_first;
      logic [SAMPLE_BITS-1:0] y_first;
      logic [SAMPLE_BITS-1:0] x_second;
      logic [SAMPLE_BITS-1:0] y_second;
   } touch_sample_type;

   typedef struct packed {
      logic pressed;
      logic [COORD_BITS-1:0] screen_x;
      logic [COORD_BITS-1:0] screen_y;
   } touch_point_type;

   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_PREDICTED,
      ROW_TYPED
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      csr_index_type csr;
      logic [CSR_DATA_BITS-1:0] csr_value;
      touch_sample_type sample;
      touch_point_type point;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   tcm_req_if req_chan();
   tcm_rsp_if rsp_chan();

   touch_coordinate_mapper_top uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Local copy of the calibration registers, kept in step with every write.
   logic [SAMPLE_BITS-1:0] cal_x_min = RAW_MIN_RESET;
   logic [SAMPLE_BITS-1:0] cal_x_max = RAW_MAX_RESET;
   logic [SAMPLE_BITS-1:0] cal_y_min = RAW_MIN_RESET;
   logic [SAMPLE_BITS-1:0] cal_y_max = RAW_MAX_RESET;
   logic [COORD_BITS-1:0] cal_width = WIDTH_RESET;
   logic [COORD_BITS-1:0] cal_height = HEIGHT_RESET;
   logic [ORIENT_BITS-1:0] cal_orientation = ORIENT_RESET;
   logic [SAMPLE_BITS-1:0] cal_threshold = THRESHOLD_RESET;

   touch_point_type expected_points[$];
   int failures = 0;
   int words_sent = 0;
   int directed_words = 0;
   int results_checked = 0;
   int touched_results = 0;
   int settings_written = 0;
   int sink_stall_mode = 0;
   bit long_hold_request = 1'b0;

   always #5 clock = ~clock;

   initial begin
      #10_000_000;
      $display("Timeout with %0d result words still outstanding.", expected_points.size());
      $display("Regression FAIL");
      $finish;
   end

   function automatic longint map_raw_to_pixels(logic [SAMPLE_BITS-1:0] raw,
                                                logic [SAMPLE_BITS-1:0] lo,
                                                logic [SAMPLE_BITS-1:0] hi,
                                                logic [COORD_BITS-1:0] size);
      longint span;
      span = longint'(hi) - longint'(lo);
      if (span <= 0) return 0;
      // Signed division truncates toward zero, as the hardware divider must.
      return ((longint'(raw) - longint'(lo)) * longint'(size)) / span;
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp_to_screen(longint v, bit invert,
                                                             logic [COORD_BITS-1:0] size);
      longint c;
      c = v;
      if (size == 0) return '0;
      if (invert) c = longint'(size) - 1 - c;
      if (c < 0) c = 0;
      if (c >= longint'(size)) c = longint'(size) - 1;
      return c[COORD_BITS-1:0];
   endfunction

   function automatic touch_point_type predict_touch_point(touch_sample_type s);
      touch_point_type p;
      logic [SAMPLE_BITS:0] sum_x, sum_y;
      logic [SAMPLE_BITS-1:0] avg_x, avg_y;
      longint px, py;
      p = '0;
      if (s.pressure <= cal_threshold) return p;
      sum_x = {1'b0, s.x_first} + {1'b0, s.x_second};
      sum_y = {1'b0, s.y_first} + {1'b0, s.y_second};
      avg_x = sum_x[SAMPLE_BITS:1];
      avg_y = sum_y[SAMPLE_BITS:1];
      // With swapped axes each raw axis still uses its own calibration span.
      if (cal_orientation[ORIENT_SWAP]) begin
         px = map_raw_to_pixels(avg_y, cal_y_min, cal_y_max, cal_width);
         py = map_raw_to_pixels(avg_x, cal_x_min, cal_x_max, cal_height);
      end else begin
         px = map_raw_to_pixels(avg_x, cal_x_min, cal_x_max, cal_width);
         py = map_raw_to_pixels(avg_y, cal_y_min, cal_y_max, cal_height);
      end
      p.pressed = 1'b1;
      p.screen_x = clamp_to_screen(px, cal_orientation[ORIENT_INV_X], cal_width);
      p.screen_y = clamp_to_screen(py, cal_orientation[ORIENT_INV_Y], cal_height);
      return p;
   endfunction

   function automatic void report_failure(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
   endfunction

   always @(posedge clock) begin : result_check
      touch_point_type want, seen;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen = '{rsp_chan.pressed, rsp_chan.screen_x, rsp_chan.screen_y};
         if (expected_points.size() == 0) begin
            report_failure($sformatf("unexpected result word pressed=%0b x=%0d y=%0d",
                                     seen.pressed, seen.screen_x, seen.screen_y));
         end else begin
            want = expected_points.pop_front();
            results_checked++;
            if (want.pressed) touched_results++;
            if (seen.pressed !== want.pressed || seen.screen_x !== want.screen_x ||
                seen.screen_y !== want.screen_y) begin
               report_failure($sformatf(
                  "result %0d: expected pressed=%0b x=%0d y=%0d, got pressed=%0b x=%0d y=%0d",
                  results_checked, want.pressed, want.screen_x, want.screen_y,
                  seen.pressed, seen.screen_x, seen.screen_y));
            end
         end
      end
   end

   function automatic int pick_gap(int mode);
      int r;
      r = $urandom_range(0, 99);
      if (mode == 0) return 0;
      if (r < ((mode == 1) ? 2 : 5)) return $urandom_range(20, 60);
      if (r < ((mode == 1) ? 20 : 55)) return $urandom_range(1, 3);
      return 0;
   endfunction

   // The receiver counts its own stalls, including the long hold-off.
   initial begin : result_sink
      int stall;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            stall = LONG_HOLD_CYCLES;
         end else begin
            stall = pick_gap(sink_stall_mode);
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic write_setting(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      case (idx)
         CSR_RAW_X_MIN: cal_x_min = value[SAMPLE_BITS-1:0];
         CSR_RAW_X_MAX: cal_x_max = value[SAMPLE_BITS-1:0];
         CSR_RAW_Y_MIN: cal_y_min = value[SAMPLE_BITS-1:0];
         CSR_RAW_Y_MAX: cal_y_max = value[SAMPLE_BITS-1:0];
         CSR_SCREEN_WIDTH: cal_width = value[COORD_BITS-1:0];
         CSR_SCREEN_HEIGHT: cal_height = value[COORD_BITS-1:0];
         CSR_ORIENTATION: cal_orientation = value[ORIENT_BITS-1:0];
         CSR_PRESS_THRESHOLD: cal_threshold = value[SAMPLE_BITS-1:0];
         default: ;
      endcase
      settings_written++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_word(touch_sample_type s, touch_point_type want);
      @(negedge clock);
      expected_points.push_back(want);
      req_chan.valid <= 1'b1;
      req_chan.pressure <= s.pressure;
      req_chan.x_first <= s.x_first;
      req_chan.y_first <= s.y_first;
      req_chan.x_second <= s.x_second;
      req_chan.y_second <= s.y_second;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic hold_sender(int cycles);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Registers only change once every outstanding word has come back.
   task automatic drain_pending();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_points.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_reading(logic [SAMPLE_BITS-1:0] a,
                                                           logic [SAMPLE_BITS-1:0] b);
      int lo_v, hi_v, r;
      lo_v = (a < b) ? int'(a) : int'(b);
      hi_v = (a < b) ? int'(b) : int'(a);
      r = $urandom_range(0, 99);
      if (r < 70) begin
         lo_v = (lo_v > 40) ? lo_v - 40 : 0;
         hi_v = (hi_v < MAX_SAMPLE - 40) ? hi_v + 40 : MAX_SAMPLE;
         return SAMPLE_BITS'($urandom_range(hi_v, lo_v));
      end
      if (r < 85) return SAMPLE_BITS'($urandom_range(MAX_SAMPLE, 0));
      return ($urandom_range(0, 1) == 1) ? SAMPLE_BITS'(MAX_SAMPLE) : '0;
   endfunction

   // The second reading of a pair usually sits close to the first.
   function automatic logic [SAMPLE_BITS-1:0] pick_partner(logic [SAMPLE_BITS-1:0] first);
      int v;
      if ($urandom_range(0, 4) == 0) return SAMPLE_BITS'($urandom_range(MAX_SAMPLE, 0));
      v = int'(first) + int'($urandom_range(0, 16)) - 8;
      if (v < 0) v = 0;
      if (v > MAX_SAMPLE) v = MAX_SAMPLE;
      return SAMPLE_BITS'(v);
   endfunction

   function automatic touch_sample_type random_sample();
      touch_sample_type s;
      int r;
      r = $urandom_range(0, 99);
      if (r < 85 && int'(cal_threshold) < MAX_SAMPLE)
         s.pressure = SAMPLE_BITS'($urandom_range(MAX_SAMPLE, int'(cal_threshold) + 1));
      else if (r < 95)
         s.pressure = SAMPLE_BITS'($urandom_range(int'(cal_threshold), 0));
      else
         s.pressure = SAMPLE_BITS'($urandom_range(MAX_SAMPLE, 0));
      s.x_first = pick_reading(cal_x_min, cal_x_max);
      s.x_second = pick_partner(s.x_first);
      s.y_first = pick_reading(cal_y_min, cal_y_max);
      s.y_second = pick_partner(s.y_first);
      return s;
   endfunction

   function automatic void pick_span(output logic [SAMPLE_BITS-1:0] lo,
                                     output logic [SAMPLE_BITS-1:0] hi);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         lo = SAMPLE_BITS'($urandom_range(MAX_SAMPLE, 0));
         hi = lo;
      end else if (r == 1) begin
         hi = SAMPLE_BITS'($urandom_range(2000, 0));
         lo = SAMPLE_BITS'($urandom_range(MAX_SAMPLE, 2001));
      end else if (r == 2) begin
         lo = '0;
         hi = SAMPLE_BITS'(MAX_SAMPLE);
      end else begin
         lo = SAMPLE_BITS'($urandom_range(1000, 0));
         hi = SAMPLE_BITS'($urandom_range(MAX_SAMPLE, 3000));
      end
   endfunction

   function automatic logic [COORD_BITS-1:0] pick_size();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r < 3) return COORD_BITS'(1);
      if (r < 5) return COORD_BITS'(MAX_COORD);
      return COORD_BITS'($urandom_range(800, 1));
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_threshold();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return SAMPLE_BITS'(MAX_SAMPLE - 1);
      if (r == 2) return SAMPLE_BITS'($urandom_range(MAX_SAMPLE, 0));
      return SAMPLE_BITS'($urandom_range(300, 0));
   endfunction

   // Phase 1 spans the full raw and screen range; phase 2 shrinks the screen to one pixel.
   task automatic apply_random_setting(int phase);
      logic [SAMPLE_BITS-1:0] lo, hi;
      pick_span(lo, hi);
      if (phase == 1) begin
         lo = '0;
         hi = SAMPLE_BITS'(MAX_SAMPLE);
      end
      write_setting(CSR_RAW_X_MIN, lo);
      write_setting(CSR_RAW_X_MAX, hi);
      pick_span(lo, hi);
      if (phase == 1) begin
         lo = '0;
         hi = SAMPLE_BITS'(MAX_SAMPLE);
      end
      write_setting(CSR_RAW_Y_MIN, lo);
      write_setting(CSR_RAW_Y_MAX, hi);
      write_setting(CSR_SCREEN_WIDTH, (phase == 1) ? COORD_BITS'(MAX_COORD) :
                                      (phase == 2) ? COORD_BITS'(1) : pick_size());
      write_setting(CSR_SCREEN_HEIGHT, (phase == 1) ? COORD_BITS'(MAX_COORD) :
                                       (phase == 2) ? COORD_BITS'(1) : pick_size());
      // Upper data bits are junk for the orientation register.
      write_setting(CSR_ORIENTATION, CSR_DATA_BITS'($urandom_range(MAX_CSR_DATA, 0)));
      write_setting(CSR_PRESS_THRESHOLD, (phase == 1) ? '0 : pick_threshold());
   endtask

   function automatic script_row_type setting_row(csr_index_type idx, int value);
      script_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.csr = idx;
      row.csr_value = value[CSR_DATA_BITS-1:0];
      return row;
   endfunction

   function automatic script_row_type word_row(int p, int xa, int ya, int xb, int yb);
      script_row_type row;
      row = '0;
      row.kind = ROW_PREDICTED;
      row.sample = '{p[SAMPLE_BITS-1:0], xa[SAMPLE_BITS-1:0], ya[SAMPLE_BITS-1:0],
                     xb[SAMPLE_BITS-1:0], yb[SAMPLE_BITS-1:0]};
      return row;
   endfunction

   function automatic script_row_type checked_row(int p, int xa, int ya, int xb, int yb,
                                                  int touched, int sx, int sy);
      script_row_type row;
      row = word_row(p, xa, ya, xb, yb);
      row.kind = ROW_TYPED;
      row.point = '{touched[0], sx[COORD_BITS-1:0], sy[COORD_BITS-1:0]};
      return row;
   endfunction

   initial begin : stimulus
      script_row_type directed_script[$];
      touch_sample_type sample;
      touch_point_type want;
      int gap;
      int send_mode;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.pressure = '0;
      req_chan.x_first = '0;
      req_chan.y_first = '0;
      req_chan.x_second = '0;
      req_chan.y_second = '0;

      directed_script = '{
         // Reset calibration: 200..3900 raw onto 320 x 240, threshold 100.
         checked_row(0, 4095, 4095, 4095, 4095, 0, 0, 0),
         checked_row(100, 2000, 2000, 2000, 2000, 0, 0, 0),
         checked_row(101, 200, 200, 200, 200, 1, 0, 0),
         checked_row(4095, 4095, 4095, 4095, 4095, 1, 319, 239),
         checked_row(4095, 0, 0, 0, 0, 1, 0, 0),
         word_row(2048, 4095, 1365, 0, 2730),
         word_row(3000, 1001, 1849, 1002, 1850),
         word_row(2730, 1365, 2730, 1365, 2730),
         setting_row(CSR_ORIENTATION, 1),
         word_row(500, 3000, 1000, 3000, 1000),
         setting_row(CSR_ORIENTATION, 2),
         checked_row(500, 200, 200, 200, 200, 1, 319, 0),
         setting_row(CSR_ORIENTATION, 4),
         word_row(500, 1500, 3900, 1500, 3900),
         setting_row(CSR_ORIENTATION, 7),
         word_row(4095, 300, 3800, 301, 3801),
         // Empty X span and reversed Y span.
         setting_row(CSR_ORIENTATION, 0),
         setting_row(CSR_RAW_X_MAX, 200),
         setting_row(CSR_RAW_Y_MAX, 100),
         checked_row(4095, 4095, 4095, 4095, 4095, 1, 0, 0),
         setting_row(CSR_ORIENTATION, 6),
         checked_row(4095, 1000, 1000, 1000, 1000, 1, 319, 239),
         setting_row(CSR_SCREEN_WIDTH, 0),
         setting_row(CSR_SCREEN_HEIGHT, 0),
         checked_row(4095, 1000, 1000, 1000, 1000, 1, 0, 0),
         // Full raw range, widest and narrowest screen, highest usable threshold.
         setting_row(CSR_RAW_X_MIN, 0),
         setting_row(CSR_RAW_X_MAX, 4095),
         setting_row(CSR_RAW_Y_MIN, 0),
         setting_row(CSR_RAW_Y_MAX, 4095),
         setting_row(CSR_SCREEN_WIDTH, 4095),
         setting_row(CSR_SCREEN_HEIGHT, 1),
         setting_row(CSR_ORIENTATION, 0),
         setting_row(CSR_PRESS_THRESHOLD, 4094),
         checked_row(4094, 4095, 4095, 4095, 4095, 0, 0, 0),
         word_row(4095, 4095, 4095, 4095, 4095),
         word_row(4095, 0, 0, 0, 0),
         setting_row(CSR_PRESS_THRESHOLD, 0),
         checked_row(0, 4095, 4095, 4095, 4095, 0, 0, 0),
         word_row(1, 2048, 2048, 2047, 2047),
         setting_row(CSR_ORIENTATION, 1),
         word_row(1, 4095, 0, 4095, 0)
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_script[i]) begin
         if (directed_script[i].kind == ROW_CSR) begin
            drain_pending();
            write_setting(directed_script[i].csr, directed_script[i].csr_value);
         end else begin
            gap = pick_gap(1);
            if (gap > 0) hold_sender(gap);
            want = (directed_script[i].kind == ROW_TYPED) ? directed_script[i].point :
                   predict_touch_point(directed_script[i].sample);
            send_word(directed_script[i].sample, want);
            directed_words++;
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_pending();
         apply_random_setting(phase);
         send_mode = phase % 3;
         sink_stall_mode = (phase / 3) % 3;
         // Stop taking results for a long stretch while words keep coming,
         // so the pipeline fills and the input stalls.
         if (phase == HOLD_PHASE) begin
            send_mode = 0;
            long_hold_request = 1'b1;
         end
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if (phase == PAUSE_PHASE && n == WORDS_PER_PHASE / 2) drain_pending();
            gap = pick_gap(send_mode);
            if (gap > 0) hold_sender(gap);
            sample = random_sample();
            send_word(sample, predict_touch_point(sample));
         end
      end

      drain_pending();
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (expected_points.size() != 0)
         report_failure($sformatf("%0d expected result words never arrived",
                                  expected_points.size()));

      $display("Sent %0d words (%0d directed) and checked %0d results, %0d of them touched.",
               words_sent, directed_words, results_checked, touched_results);
      $display("Made %0d register writes over %0d random calibrations; %0d mismatches.",
               settings_written, RANDOM_PHASES, failures);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/tcm_pkg.sv
hdl/tcm_chan_if.sv
hdl/tcm_axis.sv
hdl/touch_coordinate_mapper_top.sv
verif/testbench.sv
